FILE: rtl/ufrc_pkg.sv
`default_nettype none
package ufrc_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CMP_W = (TIMER_BITS + 1 > 17) ? TIMER_BITS + 1 : 17;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_TAG   = 3'd1;
  localparam logic [2:0] PH_LENH  = 3'd2;
  localparam logic [2:0] PH_LENL  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CHECK = 3'd5;
  localparam logic [2:0] PH_TAIL  = 3'd6;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_TAIL = 3'd1;
  localparam logic [2:0] ST_BAD_SUM  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  localparam logic [1:0] REG_HEAD    = 2'd0;
  localparam logic [1:0] REG_TAIL    = 2'd1;
  localparam logic [1:0] REG_MAX_LEN = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  localparam logic [11:0] MAX_LEN_RST = 12'd300;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [3:0]  LEN_HI_MASK = 4'hf;

  typedef struct packed {
    logic [7:0]  head_byte;
    logic [7:0]  tail_byte;
    logic [11:0] max_length;
    logic [15:0] byte_timeout;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [11:0] byte_index;
    logic [7:0]  frame_tag;
    logic [11:0] frame_length;
    logic [2:0]  status;
  } res_t;

  // handshake between input register and deframer
  typedef struct packed {
    logic  valid;
    item_t item;
  } in_stage_t;

endpackage
`default_nettype wire

FILE: rtl/ufrc_if.sv
`default_nettype none
interface ufrc_in_if import ufrc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, opcode, rx_byte, input ready);
  modport sink (input valid, opcode, rx_byte, output ready);
endinterface

interface ufrc_out_if import ufrc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [11:0] byte_index;
  logic [7:0]  frame_tag;
  logic [11:0] frame_length;
  logic [2:0]  status;

  modport source (output valid, kind, payload_byte, byte_index, frame_tag, frame_length,
                  status, input ready);
  modport sink (input valid, kind, payload_byte, byte_index, frame_tag, frame_length,
                status, output ready);
endinterface

interface ufrc_cfg_if import ufrc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ufrc_cfg_regs.sv
`default_nettype none
module ufrc_cfg_regs import ufrc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_valid_i,
  input  wire logic [1:0]  wr_index_i,
  input  wire logic [15:0] wr_data_i,
  output logic             wr_ready_o,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (wr_index_i)
        REG_HEAD:    cfg_d.head_byte    = wr_data_i[7:0];
        REG_TAIL:    cfg_d.tail_byte    = wr_data_i[7:0];
        REG_MAX_LEN: cfg_d.max_length   = wr_data_i[11:0];
        REG_TIMEOUT: cfg_d.byte_timeout = wr_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte    <= 8'd0;
      cfg_q.tail_byte    <= 8'd0;
      cfg_q.max_length   <= MAX_LEN_RST;
      cfg_q.byte_timeout <= TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ufrc_in_stage.sv
`default_nettype none
module ufrc_in_stage import ufrc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic       opcode_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            ready_o,
  input  wire logic       take_i,
  output in_stage_t       stage_o
);

  logic  vld_q, vld_d;
  item_t item_q, item_d;
  logic  fire;

  assign ready_o = !vld_q || take_i;
  assign fire    = valid_i && ready_o;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (fire) begin
      vld_d          = 1'b1;
      item_d.opcode  = opcode_i;
      item_d.rx_byte = rx_byte_i;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign stage_o.valid = vld_q;
  assign stage_o.item  = item_q;

endmodule
`default_nettype wire

FILE: rtl/ufrc_deframer.sv
`default_nettype none
module ufrc_deframer import ufrc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire in_stage_t stage_i,
  output logic           take_o,
  input  wire logic      res_ready_i,
  output logic           res_valid_o,
  output res_t           res_o
);

  logic [2:0]            phase_q, phase_d;
  logic [7:0]            tag_q, tag_d;
  logic [11:0]           len_q, len_d;
  logic [11:0]           count_q, count_d;
  logic [7:0]            sum_q, sum_d;
  logic [7:0]            check_q, check_d;
  logic [TIMER_BITS-1:0] idle_q, idle_d;
  logic                  out_vld_q, out_vld_d;
  res_t                  res_q, res_d;

  logic                  emit;
  res_t                  res_c;
  logic [CMP_W-1:0]      next_ticks;
  logic [CMP_W-1:0]      timeout_ext;
  logic [11:0]           len_new;
  logic [11:0]           count_inc;
  logic [7:0]            b;

  assign take_o      = stage_i.valid && (!out_vld_q || res_ready_i);
  assign b           = stage_i.item.rx_byte;
  assign next_ticks  = CMP_W'(idle_q) + CMP_W'(1);
  assign timeout_ext = CMP_W'(cfg_i.byte_timeout);
  assign len_new     = {len_q[11:8], b};
  assign count_inc   = count_q + 12'd1;

  always_comb begin
    phase_d = phase_q;
    tag_d   = tag_q;
    len_d   = len_q;
    count_d = count_q;
    sum_d   = sum_q;
    check_d = check_q;
    idle_d  = idle_q;
    emit    = 1'b0;
    res_c.kind         = KIND_END;
    res_c.payload_byte = 8'd0;
    res_c.byte_index   = 12'd0;
    res_c.frame_tag    = tag_q;
    res_c.frame_length = len_q;
    res_c.status       = ST_OK;

    if (stage_i.item.opcode == OP_TICK) begin
      if (phase_q != PH_HUNT) begin
        if (next_ticks > timeout_ext) begin
          emit         = 1'b1;
          res_c.status = ST_TIMEOUT;
          phase_d      = PH_HUNT;
          idle_d       = '0;
        end else if (next_ticks[TIMER_BITS]) begin
          // counter saturates instead of wrapping
          idle_d = '1;
        end else begin
          idle_d = next_ticks[TIMER_BITS-1:0];
        end
      end
    end else begin
      idle_d = '0;
      case (phase_q)
        PH_HUNT: begin
          if (b == cfg_i.head_byte) begin
            phase_d = PH_TAG;
            tag_d   = 8'd0;
            len_d   = 12'd0;
            count_d = 12'd0;
            sum_d   = 8'd0;
            check_d = 8'd0;
          end
        end
        PH_TAG: begin
          tag_d   = b;
          sum_d   = b;
          phase_d = PH_LENH;
        end
        PH_LENH: begin
          len_d   = {b[3:0] & LEN_HI_MASK, 8'd0};
          sum_d   = sum_q + b;
          phase_d = PH_LENL;
        end
        PH_LENL: begin
          len_d = len_new;
          sum_d = sum_q + b;
          if (len_new > cfg_i.max_length) begin
            emit               = 1'b1;
            res_c.frame_length = len_new;
            res_c.status       = ST_TOO_LONG;
            phase_d            = PH_HUNT;
          end else if (len_new == 12'd0) begin
            phase_d = PH_CHECK;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          emit               = 1'b1;
          res_c.kind         = KIND_PAYLOAD;
          res_c.payload_byte = b;
          res_c.byte_index   = count_q;
          sum_d              = sum_q + b;
          count_d            = count_inc;
          if (count_inc >= len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          check_d = b;
          phase_d = PH_TAIL;
        end
        PH_TAIL: begin
          emit    = 1'b1;
          phase_d = PH_HUNT;
          // tail mismatch wins over a bad check byte
          if (b != cfg_i.tail_byte) begin
            res_c.status = ST_BAD_TAIL;
          end else if (check_q != ~sum_q) begin
            res_c.status = ST_BAD_SUM;
          end else begin
            res_c.status = ST_OK;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (out_vld_q && res_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (take_o && emit) begin
      out_vld_d = 1'b1;
      res_d     = res_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      tag_q     <= 8'd0;
      len_q     <= 12'd0;
      count_q   <= 12'd0;
      sum_q     <= 8'd0;
      check_q   <= 8'd0;
      idle_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (take_o) begin
        phase_q <= phase_d;
        tag_q   <= tag_d;
        len_q   <= len_d;
        count_q <= count_d;
        sum_q   <= sum_d;
        check_q <= check_d;
        idle_q  <= idle_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

FILE: rtl/uart_frame_receiver_checker.sv
`default_nettype none
// Frame receiver for a byte stream of head, tag, two length bytes, payload,
// check byte and tail. Each input transfer is one received byte or one idle
// tick; payload bytes come out as they arrive, and every frame end or abort
// gives one status result (ok, bad tail, bad checksum, too long, timeout).
// One input transfer is taken per clock as long as the result side keeps
// taking transfers: each is held in the input register, decoded by the byte
// state machine and, if it gives a result, lands in the result register. The
// config channel is always ready; change registers only while no frame is in
// flight.
module uart_frame_receiver_checker import ufrc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ufrc_in_if.sink   in_i,
  ufrc_out_if.source out_o,
  ufrc_cfg_if.sink  cfg_i
);

  cfg_t      cfg;
  in_stage_t stage;
  logic      take;
  res_t      res;
  logic      res_valid;

  ufrc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  ufrc_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .opcode_i  (in_i.opcode),
    .rx_byte_i (in_i.rx_byte),
    .ready_o   (in_i.ready),
    .take_i    (take),
    .stage_o   (stage)
  );

  ufrc_deframer u_dfr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .stage_i     (stage),
    .take_o      (take),
    .res_ready_i (out_o.ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_o.valid        = res_valid;
  assign out_o.kind         = res.kind;
  assign out_o.payload_byte = res.payload_byte;
  assign out_o.byte_index   = res.byte_index;
  assign out_o.frame_tag    = res.frame_tag;
  assign out_o.frame_length = res.frame_length;
  assign out_o.status       = res.status;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none
module testbench import ufrc_pkg::*; ();

  localparam int QUIET_LIMIT = 2000;
  localparam int ITEM_GOAL   = 1850;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic [2:0]            phase;
    logic [7:0]            tag;
    logic [11:0]           len;
    logic [11:0]           count;
    logic [7:0]            sum;
    logic [7:0]            check;
    logic [TIMER_BITS-1:0] idle;
  } frame_state_t;

  logic clk_i;
  logic rst_ni;

  ufrc_in_if  in_if ();
  ufrc_out_if out_if ();
  ufrc_cfg_if cfg_if ();

  uart_frame_receiver_checker uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  cfg_t         live_cfg;
  frame_state_t pred_state;
  frame_state_t gen_state;
  item_t        pending[$];
  res_t         due_results[$];

  int items_queued;
  int items_taken;
  int live_items;
  int settings;
  int errors;
  int payload_checked;
  int end_by_status[8];

  // sender burst and gap counters
  int gap_left;
  int burst_left;

  // receiver stall pattern
  int rx_mode;
  int mode_left;
  int stall_left;
  int ticker;

  int quiet;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // one received byte or tick through the deframer; returns 1 when a result comes out
  function automatic bit deframe_step(inout frame_state_t st, input cfg_t c, input item_t it,
                                      output res_t r);
    logic [2:0]      fin;
    bit              done;
    bit              emit;
    longint unsigned nxt;
    longint unsigned timer_top;
    r = '0;
    fin = ST_OK;
    done = 1'b0;
    emit = 1'b0;
    timer_top = (64'd1 << TIMER_BITS) - 1;
    if (it.opcode == OP_TICK) begin
      if (st.phase != PH_HUNT) begin
        nxt = 64'(st.idle) + 1;
        if (nxt > 64'(c.byte_timeout)) begin
          done = 1'b1;
          fin = ST_TIMEOUT;
        end else if (nxt > timer_top) begin
          st.idle = '1;
        end else begin
          st.idle = TIMER_BITS'(nxt);
        end
      end
    end else begin
      st.idle = '0;
      case (st.phase)
        PH_HUNT: begin
          if (it.rx_byte == c.head_byte) begin
            st.phase = PH_TAG;
            st.tag = '0;
            st.len = '0;
            st.count = '0;
            st.sum = '0;
            st.check = '0;
          end
        end
        PH_TAG: begin
          st.tag = it.rx_byte;
          st.sum = it.rx_byte;
          st.phase = PH_LENH;
        end
        PH_LENH: begin
          st.len = {it.rx_byte[3:0] & LEN_HI_MASK, 8'h00};
          st.sum += it.rx_byte;
          st.phase = PH_LENL;
        end
        PH_LENL: begin
          st.len[7:0] = it.rx_byte;
          st.sum += it.rx_byte;
          if (st.len > c.max_length) begin
            done = 1'b1;
            fin = ST_TOO_LONG;
          end else begin
            st.phase = (st.len == 12'd0) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          emit = 1'b1;
          r.kind = KIND_PAYLOAD;
          r.payload_byte = it.rx_byte;
          r.byte_index = st.count;
          r.frame_tag = st.tag;
          r.frame_length = st.len;
          r.status = ST_OK;
          st.sum += it.rx_byte;
          st.count += 12'd1;
          if (st.count >= st.len) st.phase = PH_CHECK;
        end
        PH_CHECK: begin
          st.check = it.rx_byte;
          st.phase = PH_TAIL;
        end
        PH_TAIL: begin
          done = 1'b1;
          // tail is judged before the checksum
          if (it.rx_byte != c.tail_byte) fin = ST_BAD_TAIL;
          else if (st.check != ~st.sum) fin = ST_BAD_SUM;
          else fin = ST_OK;
        end
        default: st.phase = PH_HUNT;
      endcase
    end
    if (done) begin
      r.kind = KIND_END;
      r.payload_byte = '0;
      r.byte_index = '0;
      r.frame_tag = st.tag;
      r.frame_length = st.len;
      r.status = fin;
      st.phase = PH_HUNT;
      st.idle = '0;
    end
    return done || emit;
  endfunction

  function automatic void check_field(input string name, input logic [11:0] want,
                                      input logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic push_item(input logic op, input logic [7:0] b);
    item_t it;
    res_t  unused;
    it.opcode = op;
    it.rx_byte = b;
    // bytes and ticks dropped while hunting do not count
    if (gen_state.phase != PH_HUNT || (op == OP_BYTE && b == live_cfg.head_byte))
      live_items++;
    void'(deframe_step(gen_state, live_cfg, it, unused));
    pending.push_back(it);
    items_queued++;
  endtask

  task automatic maybe_idle();
    int tmo;
    int n;
    tmo = int'(live_cfg.byte_timeout);
    if ($urandom_range(0, 99) < 12) begin
      n = (tmo <= 40) ? $urandom_range(1, tmo + 1) : $urandom_range(1, 6);
      repeat (n) push_item(OP_TICK, 8'($urandom));
    end
  endtask

  // len < 0 picks a random length
  task automatic send_frame(input int forced_len);
    logic [7:0]  fb[$];
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [11:0] len;
    int          mx;
    int          cut;
    mx = int'(live_cfg.max_length);
    if (forced_len >= 0) len = 12'(forced_len);
    else if (mx < 4095 && $urandom_range(0, 9) == 0)
      len = 12'($urandom_range(mx + 1, (mx + 40 > 4095) ? 4095 : mx + 40));
    else len = 12'($urandom_range(0, (mx > 24) ? 24 : mx));
    fb.push_back(live_cfg.head_byte);
    b = 8'($urandom);
    fb.push_back(b);
    sum = b;
    b = {4'($urandom), len[11:8]};
    fb.push_back(b);
    sum += b;
    b = len[7:0];
    fb.push_back(b);
    sum += b;
    if (len > mx) begin
      // leftovers after an oversized header get hunted over
      repeat ($urandom_range(0, 4)) fb.push_back(8'($urandom));
    end else begin
      repeat (len) begin
        b = ($urandom_range(0, 19) == 0) ? live_cfg.head_byte : 8'($urandom);
        fb.push_back(b);
        sum += b;
      end
      b = ~sum;
      if ($urandom_range(0, 7) == 0) b ^= 8'($urandom_range(1, 255));
      fb.push_back(b);
      b = live_cfg.tail_byte;
      if ($urandom_range(0, 7) == 0) b ^= 8'($urandom_range(1, 255));
      fb.push_back(b);
    end
    cut = ($urandom_range(0, 15) == 0) ? $urandom_range(1, fb.size() - 1) : fb.size();
    for (int i = 0; i < cut; i++) begin
      if (i != 0) maybe_idle();
      push_item(OP_BYTE, fb[i]);
    end
  endtask

  // drive bytes until the frame in progress ends
  task automatic flush_frame();
    while (gen_state.phase != PH_HUNT) begin
      case (gen_state.phase)
        PH_LENH: push_item(OP_BYTE, {4'($urandom), 4'h0});
        PH_LENL: push_item(OP_BYTE, 8'h00);
        default: push_item(OP_BYTE, 8'($urandom));
      endcase
    end
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || due_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_HEAD:    live_cfg.head_byte = value[7:0];
      REG_TAIL:    live_cfg.tail_byte = value[7:0];
      REG_MAX_LEN: live_cfg.max_length = value[11:0];
      REG_TIMEOUT: live_cfg.byte_timeout = value[15:0];
      default: ;
    endcase
  endtask

  // input driver: predicts on every accepted transfer
  always @(posedge clk_i) begin
    item_t taken;
    item_t nxt_item;
    res_t  outcome;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        taken.opcode = in_if.opcode;
        taken.rx_byte = in_if.rx_byte;
        if (deframe_step(pred_state, live_cfg, taken, outcome)) due_results.push_back(outcome);
        items_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0 || pending.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_if.valid <= 1'b0;
        end else begin
          nxt_item = pending.pop_front();
          in_if.valid <= 1'b1;
          in_if.opcode <= nxt_item.opcode;
          in_if.rx_byte <= nxt_item.rx_byte;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    bit   rdy;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.kind = out_if.kind;
        got.payload_byte = out_if.payload_byte;
        got.byte_index = out_if.byte_index;
        got.frame_tag = out_if.frame_tag;
        got.frame_length = out_if.frame_length;
        got.status = out_if.status;
        if (due_results.size() == 0) begin
          $error("result with nothing outstanding: kind %0d status %0d", got.kind, got.status);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", 12'(want.kind), 12'(got.kind));
          check_field("payload_byte", 12'(want.payload_byte), 12'(got.payload_byte));
          check_field("byte_index", want.byte_index, got.byte_index);
          check_field("frame_tag", 12'(want.frame_tag), 12'(got.frame_tag));
          check_field("frame_length", want.frame_length, got.frame_length);
          check_field("status", 12'(want.status), 12'(got.status));
          if (want.kind == KIND_END) end_by_status[want.status]++;
          else payload_checked++;
        end
      end
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      ticker++;
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = $urandom_range(0, 3) != 0;
        2: rdy = (ticker % 5) != 0 && (ticker % 7) != 3;
        default: begin
          if (stall_left == 0 && $urandom_range(0, 29) == 0) stall_left = $urandom_range(5, 40);
          rdy = stall_left == 0;
          if (stall_left != 0) stall_left--;
        end
      endcase
      out_if.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("uart_frame_receiver_checker: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [7:0]  hb;
    logic [7:0]  tb;
    logic [11:0] ml;
    logic [15:0] tmo;
    int          phase_mark;
    bit          paused;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_BYTE;
    in_if.rx_byte = 8'h00;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_HEAD;
    cfg_if.data = 16'h0000;
    live_cfg.head_byte = 8'h00;
    live_cfg.tail_byte = 8'h00;
    live_cfg.max_length = MAX_LEN_RST;
    live_cfg.byte_timeout = TIMEOUT_RST;
    pred_state = '0;
    pred_state.phase = PH_HUNT;
    gen_state = pred_state;
    items_queued = 0;
    items_taken = 0;
    live_items = 0;
    settings = 1;
    errors = 0;
    payload_checked = 0;
    foreach (end_by_status[i]) end_by_status[i] = 0;
    gap_left = 0;
    burst_left = 0;
    rx_mode = 0;
    mode_left = 0;
    stall_left = 0;
    ticker = 0;
    quiet = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: tick while hunting, then a zero length frame with a bad check byte
    push_item(OP_TICK, 8'hff);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hff);
    push_item(OP_BYTE, 8'hf0);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'h00);
    wait_idle();

    // upper data bits must be masked off
    write_reg(REG_HEAD, 16'hffa5);
    write_reg(REG_TAIL, 16'hc35a);
    write_reg(REG_MAX_LEN, 16'hf002);
    write_reg(REG_TIMEOUT, 16'd2);
    settings++;
    // oversized header, then head inside payload, idle at the limit, one tick over it
    push_item(OP_BYTE, 8'ha5);
    push_item(OP_BYTE, 8'h11);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'h03);
    push_item(OP_BYTE, 8'ha5);
    push_item(OP_BYTE, 8'h22);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'h02);
    push_item(OP_BYTE, 8'ha5);
    push_item(OP_TICK, 8'h00);
    push_item(OP_TICK, 8'h00);
    push_item(OP_BYTE, 8'h01);
    push_item(OP_TICK, 8'h00);
    push_item(OP_TICK, 8'h00);
    push_item(OP_TICK, 8'h00);
    wait_idle();

    for (int p = 0; live_items < ITEM_GOAL; p++) begin
      case (p)
        0: begin
          hb = 8'hff;
          tb = 8'h00;
          ml = 12'hfff;
          tmo = 16'hffff;
        end
        1: begin
          hb = 8'h00;
          tb = 8'hff;
          ml = 12'h000;
          tmo = 16'd1;
        end
        default: begin
          hb = 8'($urandom);
          tb = 8'($urandom);
          case ($urandom_range(0, 3))
            0: ml = 12'($urandom_range(0, 3));
            1: ml = 12'($urandom_range(4, 40));
            2: ml = MAX_LEN_RST;
            default: ml = 12'hfff;
          endcase
          case ($urandom_range(0, 2))
            0: tmo = 16'($urandom_range(1, 6));
            1: tmo = 16'($urandom_range(7, 40));
            default: tmo = 16'($urandom_range(1000, 65535));
          endcase
        end
      endcase
      write_reg(REG_HEAD, {8'($urandom), hb});
      write_reg(REG_TAIL, {8'($urandom), tb});
      write_reg(REG_MAX_LEN, {4'($urandom), ml});
      write_reg(REG_TIMEOUT, tmo);
      settings++;
      phase_mark = live_items;
      paused = 1'b0;
      if (p == 0) begin
        // one long frame, well past the reset length limit
        send_frame(600);
      end
      while (live_items < phase_mark + PHASE_ITEMS) begin
        if (!paused && live_items >= phase_mark + PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 4))
            push_item($urandom_range(0, 1) ? OP_TICK : OP_BYTE, 8'($urandom));
        send_frame(-1);
      end
      flush_frame();
      wait_idle();
    end

    $display("%0d input transfers under %0d register settings; %0d payload bytes checked",
             items_taken, settings, payload_checked);
    $display("frame ends: ok %0d, bad tail %0d, bad sum %0d, too long %0d, timeout %0d",
             end_by_status[ST_OK], end_by_status[ST_BAD_TAIL], end_by_status[ST_BAD_SUM],
             end_by_status[ST_TOO_LONG], end_by_status[ST_TIMEOUT]);
    if (errors == 0) begin
      $display("uart_frame_receiver_checker: match");
    end else begin
      $display("uart_frame_receiver_checker: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/ufrc_pkg.sv
rtl/ufrc_if.sv
rtl/ufrc_cfg_regs.sv
rtl/ufrc_in_stage.sv
rtl/ufrc_deframer.sv
rtl/uart_frame_receiver_checker.sv
tb/sv/testbench.sv
